FILE: rtl/camera_line_packet_depacketizer_core_assert.svh
// Assertion macros for the camera line packet depacketizer core.
// Each macro expands to a labeled concurrent assertion on clk, disabled during rst.
`ifndef CAMERA_LINE_PACKET_DEPACKETIZER_CORE_ASSERT_SVH
`define CAMERA_LINE_PACKET_DEPACKETIZER_CORE_ASSERT_SVH

// Same-cycle implication.
`define CLPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CLPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/clpd_pkg.sv
// Package for the camera line packet depacketizer: geometry constants, derived widths,
// operation codes and the input and result item types. No dependencies.
package clpd_pkg;

  localparam int LINE_WIDTH = 640;
  localparam int LINE_COUNT = 480;
  localparam int CAMERA_MAX = 8;
  localparam int WORDS_MAX  = 1020;

  localparam logic [31:0] TAG_FRAME_START = 32'h0100_0000;
  localparam logic [31:0] TAG_FRAME_END   = 32'h0200_0000;

  localparam int FRAME_PIXELS = LINE_WIDTH * LINE_COUNT;
  localparam int TOTAL_WIDTH  = LINE_WIDTH * CAMERA_MAX;

  localparam int COUNT_W    = 10;
  localparam int START_W    = 16;
  localparam int END_W      = START_W + 1;
  localparam int ADDR_W     = 19;
  localparam int ROW_W      = $clog2(LINE_COUNT);
  localparam int TAG_LOW_W  = $clog2(LINE_COUNT + 1);
  localparam int COL_W      = $clog2(LINE_WIDTH);
  localparam int BASE_W     = $clog2(FRAME_PIXELS);
  localparam int SUM_W      = $clog2(FRAME_PIXELS + WORDS_MAX);
  localparam int CAM_W      = $clog2(CAMERA_MAX + 1);
  // wide enough for the 4-bit camera register and a camera count up to 16
  localparam int CAM_CMP_W  = 5;

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_PIXEL  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 operation;
    logic [31:0]         line_tag;
    logic [START_W-1:0]  start_column;
    logic [COUNT_W-1:0]  word_count;
    logic [31:0]         pixel_word;
  } in_item_t;

  typedef struct packed {
    logic              pixel_valid;
    logic [2:0]        camera;
    logic [ADDR_W-1:0] pixel_address;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              frame_begin;
    logic              header_error;
    logic              frame_done;
    logic              buffer_select;
    logic [31:0]       frame_number;
  } out_item_t;

endpackage

FILE: rtl/clpd_in_if.sv
// Input channel of the depacketizer: valid/ready handshake carrying one in_item_t.
// Depends on clpd_pkg.
interface clpd_in_if import clpd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/clpd_out_if.sv
// Result channel of the depacketizer: valid/ready handshake carrying one out_item_t.
// Depends on clpd_pkg.
interface clpd_out_if import clpd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/camera_line_packet_depacketizer_core.sv
// Camera line packet depacketizer core: header and pixel word decode, frame tracking.
// Depends on clpd_pkg, clpd_in_if, clpd_out_if and the assertion macro header.
//
// Takes one item per clock at full rate: an accepted item sits in an input register,
// is decoded there and its result lands in the output register. A new item can enter
// every cycle while the output drains, but stalls while an untaken result blocks it.
// A header gives one result; each expected pixel word gives one result; a word with
// nothing outstanding is absorbed with no result. Camera and in-frame column are
// resolved once per header, so each word costs only adds and compares.
// num_cameras may only be changed while no results are outstanding.
`include "camera_line_packet_depacketizer_core_assert.svh"

module camera_line_packet_depacketizer_core import clpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata,
  clpd_in_if.sink           packet,
  clpd_out_if.source        result
);

  logic               s1_valid;
  in_item_t           s1_item;

  logic [3:0]         num_cameras;
  logic               in_frame;
  logic               fill_buffer;
  logic [31:0]        completed_frames;
  logic [COUNT_W-1:0] words_expected;
  logic [COUNT_W-1:0] word_position;
  logic               line_ok;
  logic               done_arm;
  logic [CAM_W-1:0]   cam_cnt;
  logic [BASE_W-1:0]  line_base;

  logic               out_valid;
  out_item_t          out_item;

  logic [31:0]        hdr_tag;
  logic               hdr_is_start;
  logic               hdr_line_ok;
  logic               hdr_error;
  logic [COUNT_W-1:0] hdr_count;
  logic [CAM_W-1:0]   hdr_cam;
  logic [START_W-1:0] hdr_cam_base;
  logic [COL_W-1:0]   hdr_col;
  logic [ROW_W-1:0]   hdr_row;
  logic [BASE_W-1:0]  hdr_base;
  logic               hdr_end_hit;
  logic               hdr_done;

  logic               wrd_pending;
  logic [SUM_W-1:0]   wrd_addr;
  logic               wrd_cam_ok;
  logic               wrd_write;
  logic [COUNT_W-1:0] wrd_pos_next;
  logic               wrd_done;

  logic               is_hdr;
  logic               res_produce;
  logic               res_done;
  logic               s1_fire;
  out_item_t          res;

  // header decode
  always_comb begin
    hdr_tag      = s1_item.line_tag;
    hdr_is_start = (hdr_tag == TAG_FRAME_START);
    hdr_line_ok  = (hdr_tag != 32'd0) && (hdr_tag <= 32'(LINE_COUNT));
    hdr_error    = !hdr_is_start && (hdr_tag != TAG_FRAME_END) && !hdr_line_ok;
    if (32'(s1_item.word_count) > 32'(WORDS_MAX)) begin
      hdr_count = COUNT_W'(WORDS_MAX);
    end else begin
      hdr_count = s1_item.word_count;
    end
    hdr_cam      = '0;
    hdr_cam_base = '0;
    for (int i = 1; i <= CAMERA_MAX; i++) begin
      if (END_W'(s1_item.start_column) >= END_W'(i * LINE_WIDTH)) begin
        hdr_cam      = CAM_W'(i);
        hdr_cam_base = START_W'(i * LINE_WIDTH);
      end
    end
    hdr_col     = COL_W'(s1_item.start_column - hdr_cam_base);
    hdr_row     = ROW_W'(TAG_LOW_W'(LINE_COUNT) - hdr_tag[TAG_LOW_W-1:0]);
    hdr_base    = BASE_W'(BASE_W'(hdr_row) * BASE_W'(LINE_WIDTH)) + BASE_W'(hdr_col);
    hdr_end_hit = (hdr_tag == 32'(LINE_COUNT)) &&
                  (END_W'(s1_item.start_column) + END_W'(hdr_count) == END_W'(TOTAL_WIDTH));
    hdr_done    = (hdr_count == '0) && hdr_end_hit && in_frame;
  end

  // pixel word decode
  always_comb begin
    wrd_pending  = (word_position < words_expected);
    wrd_addr     = SUM_W'(line_base) + SUM_W'(word_position);
    wrd_cam_ok   = (CAM_CMP_W'(cam_cnt) < CAM_CMP_W'(num_cameras)) &&
                   (CAM_CMP_W'(cam_cnt) < CAM_CMP_W'(CAMERA_MAX));
    wrd_write    = line_ok && wrd_cam_ok && (wrd_addr < SUM_W'(FRAME_PIXELS));
    wrd_pos_next = word_position + COUNT_W'(1);
    wrd_done     = (wrd_pos_next == words_expected) && done_arm && in_frame;
  end

  always_comb begin
    is_hdr      = (s1_item.operation == OP_HEADER);
    res_produce = is_hdr || wrd_pending;
    res_done    = is_hdr ? hdr_done : wrd_done;
    s1_fire     = s1_valid && (!res_produce || !out_valid || result.ready);

    res               = '0;
    res.frame_done    = res_done;
    res.buffer_select = fill_buffer;
    res.frame_number  = completed_frames + {31'd0, res_done};
    if (is_hdr) begin
      res.frame_begin  = hdr_is_start;
      res.header_error = hdr_error;
    end else if (wrd_write) begin
      res.pixel_valid   = 1'b1;
      res.camera        = cam_cnt[2:0];
      res.pixel_address = ADDR_W'(wrd_addr);
      res.red           = s1_item.pixel_word[29:22];
      res.green         = s1_item.pixel_word[19:12];
      res.blue          = s1_item.pixel_word[9:2];
    end
  end

  assign packet.ready = !s1_valid || s1_fire;
  assign result.valid = out_valid;
  assign result.data  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (packet.valid && packet.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (packet.valid && packet.ready) begin
      s1_item <= packet.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && res_produce) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_produce) begin
      out_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cameras <= 4'd8;
    end else if (cfg_we) begin
      num_cameras <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame         <= 1'b0;
      fill_buffer      <= 1'b0;
      completed_frames <= '0;
      words_expected   <= '0;
      word_position    <= '0;
      line_ok          <= 1'b0;
      done_arm         <= 1'b0;
    end else if (s1_fire && res_produce) begin
      if (is_hdr) begin
        words_expected <= hdr_count;
        word_position  <= '0;
        line_ok        <= hdr_line_ok;
        done_arm       <= hdr_end_hit;
        if (hdr_is_start) begin
          in_frame <= 1'b1;
        end
      end else begin
        word_position <= wrd_pos_next;
      end
      if (res_done) begin
        in_frame         <= 1'b0;
        fill_buffer      <= !fill_buffer;
        completed_frames <= completed_frames + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && is_hdr) begin
      cam_cnt   <= hdr_cam;
      line_base <= hdr_base;
    end
  end

  `CLPD_ASSERT_NOW(a_addr_in_frame, result.valid && result.data.pixel_valid, result.data.pixel_address < ADDR_W'(FRAME_PIXELS), "pixel write beyond frame")
  `CLPD_ASSERT_NOW(a_pos_bound, s1_valid || !s1_valid, word_position <= words_expected, "word position past packet end")
  `CLPD_ASSERT_NEXT(a_done_closes, s1_fire && res_produce && res_done, !in_frame, "frame still open after completion")
  `CLPD_ASSERT_NOW(a_done_flips, result.valid && result.data.frame_done, fill_buffer != result.data.buffer_select, "buffer select not toggled on frame done")

endmodule

FILE: bench/tb_camera_line_packet_depacketizer_core.sv
// Testbench for camera_line_packet_depacketizer_core: bursty packet source, stalling
// result sink, in-bench decoder that predicts every result. Depends on clpd_pkg,
// clpd_in_if, clpd_out_if and the core.
module tb_camera_line_packet_depacketizer_core import clpd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  bit clk = 0;
  logic rst;
  logic cfg_we;
  logic [3:0] cfg_wdata;

  clpd_in_if packet_if();
  clpd_out_if result_if();

  camera_line_packet_depacketizer_core u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .packet(packet_if),
    .result(result_if)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  in_item_t items_to_send[$];
  out_item_t results_due[$];
  int errors = 0;
  int queued_items = 0;
  bit in_fire = 0;

  // decoder state
  logic [31:0] cur_tag = '0;
  logic [15:0] cur_start = '0;
  int unsigned words_due = 0;
  int unsigned word_idx = 0;
  bit frame_open = 0;
  bit fill_buf = 0;
  logic [31:0] frames_done = '0;
  logic [3:0] cams_reg = 4'd8;

  // sink hold-off requests
  int hold_requests = 0;
  int hold_served = 0;

  function automatic bit frame_closes(input int unsigned count);
    if (cur_tag == LINE_COUNT && frame_open &&
        int'(cur_start) + count == TOTAL_WIDTH) begin
      frame_open = 0;
      fill_buf = ~fill_buf;
      frames_done = frames_done + 1;
      return 1;
    end
    return 0;
  endfunction

  task automatic decode_item(input in_item_t it);
    out_item_t r;
    int unsigned cnt, cams, cam, col, row, addr;
    bit buf_before;
    bit done;
    bit has_result;
    r = '0;
    buf_before = fill_buf;
    done = 0;
    has_result = 1;
    if (it.operation == OP_HEADER) begin
      cnt = it.word_count;
      if (cnt > WORDS_MAX) cnt = WORDS_MAX;
      cur_tag = it.line_tag;
      cur_start = it.start_column;
      words_due = cnt;
      word_idx = 0;
      if (it.line_tag == TAG_FRAME_START) begin
        frame_open = 1;
        r.frame_begin = 1;
      end else if (it.line_tag != TAG_FRAME_END &&
                   (it.line_tag == 0 || it.line_tag > LINE_COUNT)) begin
        r.header_error = 1;
      end
      if (cnt == 0) done = frame_closes(0);
    end else if (word_idx >= words_due) begin
      has_result = 0;
    end else begin
      cams = (cams_reg < CAMERA_MAX) ? cams_reg : CAMERA_MAX;
      if (cur_tag >= 1 && cur_tag <= LINE_COUNT) begin
        cam = cur_start / LINE_WIDTH;
        col = cur_start % LINE_WIDTH;
        row = LINE_COUNT - cur_tag;
        addr = row * LINE_WIDTH + col + word_idx;
        if (cam < cams && addr < FRAME_PIXELS) begin
          r.pixel_valid = 1;
          r.camera = cam[2:0];
          r.pixel_address = addr[ADDR_W-1:0];
          r.red = it.pixel_word[29:22];
          r.green = it.pixel_word[19:12];
          r.blue = it.pixel_word[9:2];
        end
      end
      word_idx = word_idx + 1;
      if (word_idx == words_due) done = frame_closes(words_due);
    end
    if (has_result) begin
      r.frame_done = done;
      r.buffer_select = buf_before;
      r.frame_number = frames_done;
      results_due.push_back(r);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (results_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none actual %0h", $time, got);
    end else begin
      want = results_due.pop_front();
      check_field("pixel_valid", want.pixel_valid, got.pixel_valid);
      check_field("camera", want.camera, got.camera);
      check_field("pixel_address", want.pixel_address, got.pixel_address);
      check_field("red", want.red, got.red);
      check_field("green", want.green, got.green);
      check_field("blue", want.blue, got.blue);
      check_field("frame_begin", want.frame_begin, got.frame_begin);
      check_field("header_error", want.header_error, got.header_error);
      check_field("frame_done", want.frame_done, got.frame_done);
      check_field("buffer_select", want.buffer_select, got.buffer_select);
      check_field("frame_number", want.frame_number, got.frame_number);
    end
  endtask

  // monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      in_fire = 0;
    end else begin
      in_fire = packet_if.valid && packet_if.ready;
      if (in_fire) decode_item(packet_if.data);
      if (result_if.valid && result_if.ready) compare_result(result_if.data);
    end
  end

  // packet source: bursts with gaps, valid held until the transfer
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      packet_if.valid = 0;
      burst_left = 0;
      gap_left = 0;
    end else if (!(packet_if.valid && !in_fire)) begin
      if (packet_if.valid && in_fire) begin
        void'(items_to_send.pop_front());
        if (burst_left > 0) burst_left--;
      end
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      end
      if (gap_left > 0) begin
        gap_left--;
        packet_if.valid = 0;
      end else if (items_to_send.size() != 0) begin
        packet_if.valid = 1;
        packet_if.data = items_to_send[0];
      end else begin
        packet_if.valid = 0;
      end
    end
  end

  // result sink: stall modes that change now and then, plus long hold-offs
  int hold_left = 0;
  int mode = 0;
  int mode_left = 0;
  int pat_idx = 0;
  logic [7:0] stall_bits = 8'hff;

  always @(negedge clk) begin
    if (rst) begin
      result_if.ready = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_if.ready = 0;
      if (hold_left == 0) hold_served = hold_requests;
    end else if (hold_served != hold_requests) begin
      hold_left = 300;
      result_if.ready = 0;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 80);
        stall_bits = 8'($urandom);
      end
      mode_left--;
      pat_idx = (pat_idx + 1) % 8;
      case (mode)
        0: result_if.ready = 1;
        1: result_if.ready = 1'($urandom_range(0, 1));
        2: result_if.ready = ($urandom_range(0, 3) == 0);
        default: result_if.ready = stall_bits[pat_idx];
      endcase
    end
  end

  task automatic push_header(input logic [31:0] tag, input int start, input int cnt);
    in_item_t it;
    it.operation = OP_HEADER;
    it.line_tag = tag;
    it.start_column = START_W'(start);
    it.word_count = COUNT_W'(cnt);
    it.pixel_word = $urandom;
    items_to_send.push_back(it);
    queued_items++;
  endtask

  task automatic push_word(input logic [31:0] w);
    in_item_t it;
    it.operation = OP_PIXEL;
    it.line_tag = $urandom;
    it.start_column = START_W'($urandom);
    it.word_count = COUNT_W'($urandom);
    it.pixel_word = w;
    items_to_send.push_back(it);
    queued_items++;
  endtask

  task automatic push_words(input int n);
    for (int i = 0; i < n; i++) push_word($urandom);
  endtask

  function automatic logic [31:0] pick_line();
    case ($urandom_range(0, 9))
      0: return 1;
      1: return LINE_COUNT;
      default: return $urandom_range(1, LINE_COUNT);
    endcase
  endfunction

  task automatic build_phase(input int target);
    int first, kind, cnt, start, nwords;
    logic [31:0] tag;
    first = queued_items;
    while (queued_items - first < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        cnt = $urandom_range(0, 1);
        push_header(TAG_FRAME_START, $urandom_range(0, 65535), cnt);
        push_words(cnt);
      end else if (kind < 62) begin
        cnt = $urandom_range(0, 8);
        case ($urandom_range(0, 9))
          0: start = TOTAL_WIDTH - cnt;
          1: start = $urandom_range(TOTAL_WIDTH, 65535);
          2: start = $urandom_range(0, 7) * LINE_WIDTH + LINE_WIDTH - $urandom_range(1, 4);
          default: start = $urandom_range(0, TOTAL_WIDTH - 1);
        endcase
        push_header(pick_line(), start, cnt);
        nwords = ($urandom_range(0, 7) == 0) ? $urandom_range(0, cnt + 2) : cnt;
        push_words(nwords);
      end else if (kind < 77) begin
        if ($urandom_range(0, 1)) push_header(TAG_FRAME_START, $urandom_range(0, 65535), 0);
        cnt = $urandom_range(0, 8);
        push_header(LINE_COUNT, TOTAL_WIDTH - cnt, cnt);
        push_words(cnt);
      end else if (kind < 87) begin
        case ($urandom_range(0, 4))
          0: tag = 0;
          1: tag = $urandom_range(LINE_COUNT + 1, 32'h00ff_ffff);
          2: tag = TAG_FRAME_END;
          3: tag = TAG_FRAME_START | 32'h1;
          default: tag = $urandom;
        endcase
        cnt = $urandom_range(0, 3);
        push_header(tag, $urandom_range(0, 65535), cnt);
        push_words(cnt);
      end else if (kind < 94) begin
        // abandoned: the next header cuts it off
        push_header(pick_line(), $urandom_range(0, 65535), $urandom_range(0, 1023));
        push_words($urandom_range(0, 3));
      end else begin
        push_words($urandom_range(1, 2));
      end
    end
  endtask

  task automatic wait_idle();
    while (items_to_send.size() != 0 || packet_if.valid || results_due.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_num_cameras(input logic [3:0] v);
    @(negedge clk);
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
    cams_reg = v;
  endtask

  initial begin
    logic [3:0] cam_settings[5];
    cam_settings = '{4'd1, 4'd15, 4'd0, 4'd4, 4'd8};
    rst = 1;
    cfg_we = 0;
    cfg_wdata = '0;
    packet_if.valid = 0;
    packet_if.data = '0;
    result_if.ready = 0;
    repeat (10) @(negedge clk);
    rst = 0;

    // directed part, register at its reset value
    push_header(TAG_FRAME_START, 0, 0);
    push_header(1, 0, 2);
    push_word(32'h3fff_ffff);
    push_word(32'h0000_0000);
    push_header(LINE_COUNT, 639, 2);
    push_word(32'hffff_ffff);
    push_word(32'hc030_0c03);
    push_header(1, 639, 2);           // second word runs off the frame
    push_words(2);
    push_header(LINE_COUNT, TOTAL_WIDTH - 1, 1);
    push_words(1);
    push_header(200, TOTAL_WIDTH, 1); // camera past the last one
    push_words(1);
    push_header(0, 0, 1);
    push_words(1);
    push_header(LINE_COUNT + 1, 0, 0);
    push_header(32'hffff_ffff, 16'hffff, 0);
    push_header(TAG_FRAME_END, 0, 1);
    push_words(1);
    push_words(1);                    // stray
    push_header(5, 100, 3);
    push_words(1);
    push_header(TAG_FRAME_START, 0, 0);
    push_header(LINE_COUNT, TOTAL_WIDTH - 2, 2);
    push_words(2);
    push_header(TAG_FRAME_START, 0, 0);
    push_header(LINE_COUNT, TOTAL_WIDTH, 0);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      write_num_cameras(cam_settings[p]);
      build_phase(110);
      if (p == 0) hold_requests++;
      if (p == 4) begin
        // count above the maximum, packet cut short by the next header
        push_header(TAG_FRAME_START, 0, 0);
        push_header(LINE_COUNT, TOTAL_WIDTH - WORDS_MAX, $urandom_range(WORDS_MAX + 1, 1023));
        push_words(3);
        build_phase(30);
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (results_due.size() != 0) begin
      errors++;
      $display("%0t: results missing, expected %0d actual 0", $time, results_due.size());
    end
    if (errors == 0) begin
      $display("tb_camera_line_packet_depacketizer_core passed");
    end else begin
      $display("tb_camera_line_packet_depacketizer_core failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_camera_line_packet_depacketizer_core failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/clpd_pkg.sv
rtl/clpd_in_if.sv
rtl/clpd_out_if.sv
rtl/camera_line_packet_depacketizer_core.sv
bench/tb_camera_line_packet_depacketizer_core.sv
